>>> sv/egd_pkg.sv
package egd_pkg;

  typedef logic signed [27:0] lat_t;
  typedef logic signed [28:0] lon_t;
  typedef logic [17:0]        kpd_t;
  typedef logic [25:0]        dist_t;

  localparam lat_t LAT_MAX = 28'sd94371840;
  localparam lat_t LAT_MIN = -28'sd94371840;
  localparam lon_t LON_MAX = 29'sd188743680;
  localparam lon_t LON_MIN = -29'sd188743680;

  localparam kpd_t  KPD_RESET = 18'd113971;
  localparam dist_t DIST_MAX  = 26'd45875200;

  // Pi in Q32, split into two 17-bit halves for the exact product.
  localparam logic [63:0] PI_Q32 = 64'd13493037705;
  localparam logic [16:0] PI_HI  = 17'(PI_Q32 >> 17);
  localparam logic [16:0] PI_LO  = 17'(PI_Q32 & 64'h1FFFF);

  // Angle scaling divides by 45 * 2^25; the estimate uses 8 * pi / 45 in Q32.
  localparam logic [63:0] X_DIV    = 64'd45;
  localparam logic [31:0] X_RECIP  = 32'((PI_Q32 * 64'd8) / 64'd45);

  localparam logic [30:0] ONE_Q30 = 31'h40000000;

  localparam int COS_STEPS = 6;
  localparam logic [7:0] COS_DIV [COS_STEPS] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
  localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
    32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
    32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12)
  };

  localparam int SQRT_STEPS = 28;

endpackage

>>> sv/egd_if.sv
interface egd_pair_if;
  logic              valid;
  logic              ready;
  egd_pkg::lat_t     lat_first;
  egd_pkg::lat_t     lat_second;
  egd_pkg::lon_t     lon_first;
  egd_pkg::lon_t     lon_second;
  modport source (output valid, lat_first, lat_second, lon_first, lon_second, input ready);
  modport sink   (input valid, lat_first, lat_second, lon_first, lon_second, output ready);
endinterface

interface egd_result_if;
  logic              valid;
  logic              ready;
  egd_pkg::dist_t    distance_km;
  modport source (output valid, distance_km, input ready);
  modport sink   (input valid, distance_km, output ready);
endinterface

interface egd_cfg_if;
  logic              valid;
  logic              ready;
  egd_pkg::kpd_t     km_per_degree;
  modport source (output valid, km_per_degree, input ready);
  modport sink   (input valid, km_per_degree, output ready);
endinterface

>>> sv/egd_cos.sv
// Cosine in Q30 from the squared angle, Horner form of the Taylor series.
// Each division step takes four stages; the closing halving step takes two.
module egd_cos #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       x2,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [30:0]       cos_q30,
  output logic [SIDE_W-1:0] out_side
);

  logic              stg_v    [0:egd_pkg::COS_STEPS];
  logic [31:0]       stg_x2   [0:egd_pkg::COS_STEPS];
  logic [30:0]       stg_t    [0:egd_pkg::COS_STEPS];
  logic [SIDE_W-1:0] stg_side [0:egd_pkg::COS_STEPS];

  assign stg_v[0]    = in_valid;
  assign stg_x2[0]   = x2;
  assign stg_t[0]    = egd_pkg::ONE_Q30;
  assign stg_side[0] = in_side;

  for (genvar k = 0; k < egd_pkg::COS_STEPS; k++) begin : g_step
    logic              a_v, b_v, c_v, d_v;
    logic [31:0]       a_x2, b_x2, c_x2, d_x2;
    logic [SIDE_W-1:0] a_side, b_side, c_side, d_side;
    logic [62:0]       a_prod;
    logic [31:0]       b_val, c_val;
    logic [63:0]       b_pm;
    logic [31:0]       c_q0, c_qd;
    logic [31:0]       d_rem, d_quo;
    logic [30:0]       d_t;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v <= 1'b0;
        b_v <= 1'b0;
        c_v <= 1'b0;
        d_v <= 1'b0;
      end else if (en) begin
        a_v <= stg_v[k];
        b_v <= a_v;
        c_v <= b_v;
        d_v <= c_v;
      end
    end

    // The reciprocal estimate is at most one short; the remainder check fixes it.
    always_comb begin
      d_rem = c_val - c_qd;
      d_quo = (d_rem >= 32'(egd_pkg::COS_DIV[k])) ? c_q0 + 32'd1 : c_q0;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_x2   <= stg_x2[k];
        a_side <= stg_side[k];
        a_prod <= {31'd0, stg_x2[k]} * {32'd0, stg_t[k]};
        b_x2   <= a_x2;
        b_side <= a_side;
        b_val  <= a_prod[61:30];
        b_pm   <= {32'd0, a_prod[61:30]} * {32'd0, egd_pkg::COS_RECIP[k]};
        c_x2   <= b_x2;
        c_side <= b_side;
        c_val  <= b_val;
        c_q0   <= b_pm[63:32];
        c_qd   <= b_pm[63:32] * 32'(egd_pkg::COS_DIV[k]);
        d_x2   <= c_x2;
        d_side <= c_side;
        d_t    <= 31'(32'(egd_pkg::ONE_Q30) - d_quo);
      end
    end

    assign stg_v[k+1]    = d_v;
    assign stg_x2[k+1]   = d_x2;
    assign stg_t[k+1]    = d_t;
    assign stg_side[k+1] = d_side;
  end

  logic              e_v;
  logic [62:0]       e_prod;
  logic [SIDE_W-1:0] e_side;
  logic [30:0]       e_half;

  assign e_half = e_prod[61:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e_v       <= stg_v[egd_pkg::COS_STEPS];
      out_valid <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_prod   <= {31'd0, stg_x2[egd_pkg::COS_STEPS]} * {32'd0, stg_t[egd_pkg::COS_STEPS]};
      e_side   <= stg_side[egd_pkg::COS_STEPS];
      out_side <= e_side;
      cos_q30  <= (e_half >= egd_pkg::ONE_Q30) ? 31'd0 : egd_pkg::ONE_Q30 - e_half;
    end
  end

endmodule

>>> sv/equirectangular_geo_distance_core.sv
// Channel   Modport  Payload                                        Role
// pair      sink     lat_first, lat_second, lon_first, lon_second   coordinate pairs in
// result    source   distance_km                                    distances out
// cfg       sink     km_per_degree                                  scale register write
//
// A new pair is taken every cycle while the pipeline is not held; each result passes
// through the pipeline stages (six front stages, 26 cosine stages, four distance
// stages, 28 square-root stages and the output register).
// Reset clears every valid bit and loads km_per_degree with 111.3 km.
// The whole pipeline moves as one: it holds while a result waits unaccepted and
// pair.ready is low, so a stall neither drops nor repeats a transaction.
module equirectangular_geo_distance_core (
  input  logic          clk,
  input  logic          rst,
  egd_pair_if.sink      pair,
  egd_result_if.source  result,
  egd_cfg_if.sink       cfg
);

  localparam int SIDE_W = 55;

  // The pipeline advances whenever the output register is free or being emptied.
  logic en;
  assign en         = !result.valid || result.ready;
  assign pair.ready = en;
  assign cfg.ready  = 1'b1;

  // Scale register, unguarded: the user changes it only with no transaction in flight.
  egd_pkg::kpd_t kpd;
  always_ff @(posedge clk) begin
    if (rst) begin
      kpd <= egd_pkg::KPD_RESET;
    end else if (cfg.valid) begin
      kpd <= cfg.km_per_degree;
    end
  end

  // Stage 1: clamp the coordinates to the valid ranges.
  logic          s1_v;
  egd_pkg::lat_t s1_lat1, s1_lat2;
  egd_pkg::lon_t s1_lon1, s1_lon2;

  function automatic egd_pkg::lat_t clamp_lat(egd_pkg::lat_t v);
    if (v > egd_pkg::LAT_MAX) begin
      return egd_pkg::LAT_MAX;
    end else if (v < egd_pkg::LAT_MIN) begin
      return egd_pkg::LAT_MIN;
    end
    return v;
  endfunction

  function automatic egd_pkg::lon_t clamp_lon(egd_pkg::lon_t v);
    if (v > egd_pkg::LON_MAX) begin
      return egd_pkg::LON_MAX;
    end else if (v < egd_pkg::LON_MIN) begin
      return egd_pkg::LON_MIN;
    end
    return v;
  endfunction

  // Stage 2: twice the mean latitude and both absolute differences.
  logic              s2_v;
  logic [27:0]       s2_sum;
  logic [27:0]       s2_dlat;
  logic [28:0]       s2_dlon;
  logic signed [28:0] lat_sum, lat_diff;
  logic signed [29:0] lon_diff;
  logic [28:0]       lat_sum_abs, lat_diff_abs;
  logic [29:0]       lon_diff_abs;

  always_comb begin
    lat_sum      = {s1_lat1[27], s1_lat1} + {s1_lat2[27], s1_lat2};
    lat_diff     = {s1_lat1[27], s1_lat1} - {s1_lat2[27], s1_lat2};
    lon_diff     = {s1_lon1[28], s1_lon1} - {s1_lon2[28], s1_lon2};
    lat_sum_abs  = lat_sum[28] ? 29'(-lat_sum) : 29'(lat_sum);
    lat_diff_abs = lat_diff[28] ? 29'(-lat_diff) : 29'(lat_diff);
    lon_diff_abs = lon_diff[29] ? 30'(-lon_diff) : 30'(lon_diff);
  end

  // Stage 3: the angle products, exact and estimated, and the north-south leg.
  logic        s3_v;
  logic [59:0] s3_pq;
  logic [44:0] s3_ph, s3_pl;
  logic [45:0] s3_dyf;
  logic [28:0] s3_dlon;

  // Stage 4: angle estimate and the exact product assembled.
  logic        s4_v;
  logic [30:0] s4_q0;
  logic [63:0] s4_sp;
  logic [25:0] s4_dy;
  logic [28:0] s4_dlon;

  // Stage 5: the estimate is at most one short of the true angle; one compare
  // against the exact product settles it.
  logic        s5_v;
  logic [30:0] s5_x;
  logic [25:0] s5_dy;
  logic [28:0] s5_dlon;
  logic [63:0] next_lim;
  assign next_lim = ((64'(s4_q0) + 64'd1) * egd_pkg::X_DIV) << 25;

  // Stage 6: square of the angle for the cosine series.
  logic              s6_v;
  logic [61:0]       s6_xx;
  logic [SIDE_W-1:0] s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= pair.valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lat1 <= clamp_lat(pair.lat_first);
      s1_lat2 <= clamp_lat(pair.lat_second);
      s1_lon1 <= clamp_lon(pair.lon_first);
      s1_lon2 <= clamp_lon(pair.lon_second);

      s2_sum  <= lat_sum_abs[27:0];
      s2_dlat <= lat_diff_abs[27:0];
      s2_dlon <= lon_diff_abs[28:0];

      s3_pq   <= 60'(s2_sum) * 60'(egd_pkg::X_RECIP);
      s3_ph   <= 45'(s2_sum) * 45'(egd_pkg::PI_HI);
      s3_pl   <= 45'(s2_sum) * 45'(egd_pkg::PI_LO);
      s3_dyf  <= 46'(kpd) * 46'(s2_dlat);
      s3_dlon <= s2_dlon;

      s4_q0   <= s3_pq[58:28];
      s4_sp   <= 64'({s3_ph, 17'd0}) + 64'(s3_pl);
      s4_dy   <= s3_dyf[45:20];
      s4_dlon <= s3_dlon;

      s5_x    <= (next_lim <= s4_sp) ? s4_q0 + 31'd1 : s4_q0;
      s5_dy   <= s4_dy;
      s5_dlon <= s4_dlon;

      s6_xx   <= 62'(s5_x) * 62'(s5_x);
      s6_side <= {s5_dy, s5_dlon};
    end
  end

  logic              cos_v;
  logic [30:0]       cos_val;
  logic [SIDE_W-1:0] cos_side;

  egd_cos #(
    .SIDE_W (SIDE_W)
  ) u_cos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .x2        (s6_xx[61:30]),
    .in_side   (s6_side),
    .out_valid (cos_v),
    .cos_q30   (cos_val),
    .out_side  (cos_side)
  );

  // Stages 7 to 10: east-west leg, squares and their sum.
  logic        s7_v, s8_v, s9_v, s10_v;
  logic [48:0] s7_kcf;
  logic [25:0] s7_dy, s8_dy;
  logic [28:0] s7_dlon;
  logic [53:0] s8_dxf;
  logic [53:0] s9_dxsq;
  logic [51:0] s9_dysq;
  logic [54:0] s10_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v  <= 1'b0;
      s8_v  <= 1'b0;
      s9_v  <= 1'b0;
      s10_v <= 1'b0;
    end else if (en) begin
      s7_v  <= cos_v;
      s8_v  <= s7_v;
      s9_v  <= s8_v;
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_kcf  <= 49'(kpd) * 49'(cos_val);
      s7_dy   <= cos_side[54:29];
      s7_dlon <= cos_side[28:0];
      s8_dxf  <= 54'(s7_kcf[48:24]) * 54'(s7_dlon);
      s8_dy   <= s7_dy;
      s9_dxsq <= 54'(s8_dxf[52:26]) * 54'(s8_dxf[52:26]);
      s9_dysq <= 52'(s8_dy) * 52'(s8_dy);
      s10_sum <= 55'(s9_dxsq) + 55'(s9_dysq);
    end
  end

  // Square root, one result bit per stage, two radicand bits brought down each time.
  localparam int RAD_W = 2 * egd_pkg::SQRT_STEPS;

  logic                              sq_v    [0:egd_pkg::SQRT_STEPS];
  logic [RAD_W-1:0]                  sq_rad  [0:egd_pkg::SQRT_STEPS];
  logic [31:0]                       sq_rem  [0:egd_pkg::SQRT_STEPS];
  logic [egd_pkg::SQRT_STEPS-1:0]    sq_root [0:egd_pkg::SQRT_STEPS];

  assign sq_v[0]    = s10_v;
  assign sq_rad[0]  = RAD_W'(s10_sum);
  assign sq_rem[0]  = 32'd0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < egd_pkg::SQRT_STEPS; i++) begin : g_sqrt
    logic                           r_v;
    logic [RAD_W-1:0]               r_rad;
    logic [31:0]                    r_rem;
    logic [egd_pkg::SQRT_STEPS-1:0] r_root;
    logic [31:0]                    cur, trial;

    always_comb begin
      cur   = {sq_rem[i][29:0], sq_rad[i][RAD_W-1 -: 2]};
      trial = {2'b00, sq_root[i], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_v <= 1'b0;
      end else if (en) begin
        r_v <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_rad <= {sq_rad[i][RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
          r_rem  <= cur - trial;
          r_root <= {sq_root[i][egd_pkg::SQRT_STEPS-2:0], 1'b1};
        end else begin
          r_rem  <= cur;
          r_root <= {sq_root[i][egd_pkg::SQRT_STEPS-2:0], 1'b0};
        end
      end
    end

    assign sq_v[i+1]    = r_v;
    assign sq_rad[i+1]  = r_rad;
    assign sq_rem[i+1]  = r_rem;
    assign sq_root[i+1] = r_root;
  end

  // Output register with saturation of very long distances.
  logic [egd_pkg::SQRT_STEPS-1:0] root_final;
  assign root_final = sq_root[egd_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= sq_v[egd_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.distance_km <= (root_final > egd_pkg::SQRT_STEPS'(egd_pkg::DIST_MAX)) ?
                            egd_pkg::DIST_MAX : root_final[25:0];
    end
  end

endmodule

>>> sim/egd_tb_if.sv
`timescale 1ns / 100ps

package egd_tb_pkg;

  // One directed stimulus row; the known distance is only checked where has_known is set.
  typedef struct packed {
    egd_pkg::lat_t  lat_a;
    egd_pkg::lat_t  lat_b;
    egd_pkg::lon_t  lon_a;
    egd_pkg::lon_t  lon_b;
    logic           has_known;
    egd_pkg::dist_t known;
  } pair_row_t;
endpackage

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY     = 65;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PAIRS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  egd_pair_if   pair ();
  egd_result_if result ();
  egd_cfg_if    cfg ();

  equirectangular_geo_distance_core dut (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The scale the bench believes is loaded into the block.
  logic [17:0] scale_km;

  // Distances still owed by the block, oldest first.
  logic [25:0] owed_distances[$];
  int          mismatch_count = 0;
  int          unowed_count   = 0;
  int          cycle_count    = 0;

  // Latitudes and longitudes are pinned to the legal range before any use.
  function automatic longint pin_coord(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // Cosine of the mean latitude in Q30 by Horner form of the Taylor series.
  function automatic logic [63:0] cos_of_angle(logic [63:0] ang);
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] last;
    logic [63:0] divisors[6];
    divisors = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
    sq  = (ang * ang) >> 30;
    acc = 64'd1 << 30;
    for (int i = 0; i < 6; i++) begin
      acc = (64'd1 << 30) - ((sq * acc) >> 30) / divisors[i];
    end
    last = ((sq * acc) >> 30) / 64'd2;
    return (last >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - last;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) begin
      bit_w = bit_w >> 2;
    end
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Approximate great-circle distance in Q10 km for one pair of points.
  function automatic logic [25:0] flat_earth_distance(egd_pkg::lat_t la, egd_pkg::lat_t lb,
                                                     egd_pkg::lon_t oa, egd_pkg::lon_t ob,
                                                     logic [17:0] kpd);
    longint      lat1, lat2, lon1, lon2, lat_sum;
    logic [63:0] sum_abs, angle, cosine, scaled, north, east, span, pi_q32, lat_gap, lon_gap;
    pi_q32  = 64'd13493037705;
    lat1    = pin_coord(longint'(la), 94371840);
    lat2    = pin_coord(longint'(lb), 94371840);
    lon1    = pin_coord(longint'(oa), 188743680);
    lon2    = pin_coord(longint'(ob), 188743680);
    lat_sum = lat1 + lat2;
    sum_abs = (lat_sum < 0) ? -lat_sum : lat_sum;
    angle   = ((sum_abs * pi_q32) / 64'd360) >> 22;
    cosine  = cos_of_angle(angle);
    scaled  = (64'(kpd) * cosine) >> 24;
    lat_gap = (lat1 >= lat2) ? lat1 - lat2 : lat2 - lat1;
    lon_gap = (lon1 >= lon2) ? lon1 - lon2 : lon2 - lon1;
    north   = (64'(kpd) * lat_gap) >> 20;
    east    = (scaled * lon_gap) >> 26;
    span    = int_sqrt(east * east + north * north);
    if (span > 64'(egd_pkg::DIST_MAX)) begin
      span = 64'(egd_pkg::DIST_MAX);
    end
    return span[25:0];
  endfunction

  // A gap of random length: usually none or short, occasionally long.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 60);
  endfunction

  // Stall pattern on the result side: mostly short stalls, now and then a long one;
  // some phases run with no stalls at all.
  logic stall_free = 1'b0;
  int   hold_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (stall_free) begin
      result.ready <= 1'b1;
    end else if (hold_cycles > 0) begin
      result.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if ($urandom_range(0, 99) < 2) begin
      result.ready <= 1'b0;
      hold_cycles  <= $urandom_range(10, 60);
    end else begin
      result.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Result checking: each accepted transaction is compared with the oldest owed distance.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && result.valid && result.ready) begin
      if (owed_distances.size() == 0) begin
        unowed_count <= unowed_count + 1;
        if (mismatch_count + unowed_count < 10) begin
          $display("unexpected result transaction: distance_km=%0d", result.distance_km);
        end
      end else begin
        if (result.distance_km !== owed_distances[0]) begin
          if (mismatch_count + unowed_count < 10) begin
            $display("distance mismatch: expected %0d, got %0d",
                     owed_distances[0], result.distance_km);
          end
          mismatch_count <= mismatch_count + 1;
        end
        void'(owed_distances.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("equirectangular_geo_distance_core test failed");
      $finish;
    end
  end

  // Sends one coordinate pair and records the distance it should produce. Valid stays
  // high after acceptance so that the next pair can follow without a gap.
  task automatic send_pair(egd_pkg::lat_t la, egd_pkg::lat_t lb,
                           egd_pkg::lon_t oa, egd_pkg::lon_t ob);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      pair.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair.valid      <= 1'b1;
    pair.lat_first  <= la;
    pair.lat_second <= lb;
    pair.lon_first  <= oa;
    pair.lon_second <= ob;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
    owed_distances.push_back(flat_earth_distance(la, lb, oa, ob, scale_km));
  endtask

  // Pauses until every owed distance has come back, then lets the pipeline drain.
  task automatic wait_until_drained();
    pair.valid <= 1'b0;
    while (owed_distances.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_scale(logic [17:0] kpd);
    cfg.valid         <= 1'b1;
    cfg.km_per_degree <= kpd;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    scale_km = kpd;
    @(posedge clk);
  endtask

  // Random latitude: mostly legal, sometimes at or beyond the bounds or fully random bits.
  function automatic egd_pkg::lat_t random_lat();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      return egd_pkg::LAT_MAX;
    end
    if (roll == 1) begin
      return egd_pkg::LAT_MIN;
    end
    if (roll == 2) begin
      return egd_pkg::lat_t'($urandom());
    end
    return egd_pkg::lat_t'($signed($urandom_range(0, 188743680)) - 94371840);
  endfunction

  function automatic egd_pkg::lon_t random_lon();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      return egd_pkg::LON_MAX;
    end
    if (roll == 1) begin
      return egd_pkg::LON_MIN;
    end
    if (roll == 2) begin
      return egd_pkg::lon_t'($urandom());
    end
    return egd_pkg::lon_t'($signed($urandom_range(0, 377487360)) - 188743680);
  endfunction

  // Directed rows: extremes, clamping and saturation. A known distance is
  // given only where it follows directly from the scale at reset.
  egd_tb_pkg::pair_row_t directed_rows[14] = '{
    '{28'sd0, 28'sd0, 29'sd0, 29'sd0, 1'b1, 26'd0},
    '{egd_pkg::LAT_MAX, egd_pkg::LAT_MAX, egd_pkg::LON_MAX, egd_pkg::LON_MAX, 1'b1, 26'd0},
    '{egd_pkg::LAT_MIN, egd_pkg::LAT_MIN, egd_pkg::LON_MIN, egd_pkg::LON_MIN, 1'b1, 26'd0},
    // One degree north along the meridian at reset scale.
    '{28'sd1048576, 28'sd0, 29'sd0, 29'sd0, 1'b1, 26'd113971},
    '{egd_pkg::LAT_MAX, egd_pkg::LAT_MIN, 29'sd0, 29'sd0, 1'b0, 26'd0},
    '{28'sd0, 28'sd0, egd_pkg::LON_MAX, egd_pkg::LON_MIN, 1'b0, 26'd0},
    '{egd_pkg::LAT_MAX, egd_pkg::LAT_MIN, egd_pkg::LON_MAX, egd_pkg::LON_MIN, 1'b0, 26'd0},
    // Beyond the legal range in every field, then the raw extremes of the bits.
    '{28'sd100000000, -28'sd100000000, 29'sd200000000, -29'sd200000000, 1'b0, 26'd0},
    '{28'sh7FFFFFF, 28'sh8000000, 29'sh0FFFFFFF, 29'sh10000000, 1'b0, 26'd0},
    '{28'sh8000000, 28'sh7FFFFFF, 29'sh10000000, 29'sh0FFFFFFF, 1'b0, 26'd0},
    '{28'shFFFFFFF, 28'sh0000001, 29'sh1FFFFFFF, 29'sh00000001, 1'b0, 26'd0},
    // Poles, where the cosine collapses towards zero, then mid-latitude points.
    '{egd_pkg::LAT_MAX, egd_pkg::LAT_MAX, egd_pkg::LON_MIN, egd_pkg::LON_MAX, 1'b0, 26'd0},
    '{28'sd47185920, 28'sd47185920, 29'sd0, 29'sd104857600, 1'b0, 26'd0},
    '{-28'sd31457280, 28'sd10485760, 29'sd52428800, -29'sd5242880, 1'b0, 26'd0}
  };

  initial begin
    egd_tb_pkg::pair_row_t row;
    pair.valid        = 1'b0;
    pair.lat_first    = '0;
    pair.lat_second   = '0;
    pair.lon_first    = '0;
    pair.lon_second   = '0;
    cfg.valid         = 1'b0;
    cfg.km_per_degree = '0;
    scale_km          = egd_pkg::KPD_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_pair(row.lat_a, row.lat_b, row.lon_a, row.lon_b);
      if (row.has_known && owed_distances[$] !== row.known) begin
        $display("predictor disagrees with directed row %0d: %0d vs %0d",
                 i, owed_distances[$], row.known);
        mismatch_count++;
      end
    end

    // The sender holds off here until every owed distance has arrived.
    wait_until_drained();

    // Phases at several scales, the extremes among them; one phase runs unstalled.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_scale(18'h3FFFF);
        1: write_scale(18'h00000);
        2: write_scale(18'h00001);
        3: write_scale(18'(($urandom() & 18'h3FFFF) | 18'h2AAAA));
        4: write_scale(18'($urandom()));
        default: write_scale(egd_pkg::KPD_RESET);
      endcase
      stall_free = (phase == 5);
      for (int k = 0; k < RANDOM_PAIRS / 6; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_pair(random_lat(), random_lat(), random_lon(), random_lon());
        end else begin
          // Nearby points: the common, well-behaved case.
          egd_pkg::lat_t la;
          egd_pkg::lon_t oa;
          la = random_lat();
          oa = random_lon();
          send_pair(la, egd_pkg::lat_t'(la + $signed($urandom_range(0, 4194304)) - 2097152),
                    oa, egd_pkg::lon_t'(oa + $signed($urandom_range(0, 8388608)) - 4194304));
        end
      end
      wait_until_drained();
    end

    if (mismatch_count == 0 && unowed_count == 0 && owed_distances.size() == 0) begin
      $display("equirectangular_geo_distance_core test passed");
    end else begin
      $display("equirectangular_geo_distance_core test failed");
    end
    $finish;
  end
endmodule
